[rtl/ktas_pkg.sv]
// ----------------------------------------------------------------------------
// ktas_pkg
// Shared types and codes of the three-action key slot engine.
// ----------------------------------------------------------------------------
package ktas_pkg;

  localparam int MODE_W      = 2;
  localparam int POS_W       = 6;
  localparam int LAYER_W     = 5;
  localparam int KIND_W      = 2;
  localparam int INDEX_W     = 2;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 64;
  localparam int S_TDATA_W   = 16;
  localparam int M_TDATA_W   = 8;
  localparam int RES_DEPTH   = 3;
  localparam int RES_CNT_W   = 2;

  localparam logic [MODE_W-1:0] MODE_PRESS   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_KEY     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_LAYER   = 2'd3;

  localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

  localparam logic [INDEX_W-1:0] ACT_TAP  = 2'd0;
  localparam logic [INDEX_W-1:0] ACT_HOLD = 2'd1;
  localparam logic [INDEX_W-1:0] ACT_END  = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_SHARED_KEY   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SHARED_LAYER = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_APPLY,
    ST_EMIT
  } ktas_state_t;

  typedef struct packed {
    logic load;
    logic search;
    logic apply;
    logic advance;
  } ktas_cmd_t;

  typedef struct packed {
    logic apply_empty;
    logic last_word;
  } ktas_status_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] index;
    logic [POS_W-1:0]   position;
  } ktas_result_t;

endpackage

[rtl/ktas_ctrl.sv]
// ----------------------------------------------------------------------------
// ktas_ctrl
// Sequencer: accept a word, search the slot table, apply, emit results.
// ----------------------------------------------------------------------------
module ktas_ctrl
  import ktas_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  output logic         m_tvalid,
  input  logic         m_tready,
  input  ktas_status_t status,
  output ktas_cmd_t    cmd
);

  ktas_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
        state_next = ST_APPLY;
      end
      ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = status.apply_empty ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          cmd.advance = 1'b1;
          if (status.last_word) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/ktas_datapath.sv]
// ----------------------------------------------------------------------------
// ktas_datapath
// Slot table, shared masks, registered slot search and result buffer.
// ----------------------------------------------------------------------------
module ktas_datapath
  import ktas_pkg::*;
#(
  parameter int SLOT_COUNT  = 10,
  parameter int KEY_COUNT   = 64,
  parameter int LAYER_COUNT = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ktas_cmd_t              cmd,
  output ktas_status_t           status,
  input  logic [MODE_W-1:0]      in_mode,
  input  logic [POS_W-1:0]       in_position,
  input  logic [LAYER_W-1:0]     in_layer,
  input  logic                   in_on,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output ktas_result_t           out_word,
  output logic                   out_last
);

  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int LW = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;

  logic [KEY_COUNT-1:0]   key_mask;
  logic [LAYER_COUNT-1:0] layer_mask;

  logic [MODE_W-1:0]  mode;
  logic [POS_W-1:0]   position;
  logic [LAYER_W-1:0] layer;
  logic               on;

  logic [SLOT_COUNT-1:0] slot_active;
  logic [SLOT_COUNT-1:0] slot_held;
  logic [SLOT_COUNT-1:0] slot_first;
  logic [POS_W-1:0]      slot_position [SLOT_COUNT];

  logic          hit_found, free_found, end_found, hit_first, end_held;
  logic [SW-1:0] hit_idx, free_idx, end_idx;
  logic [POS_W-1:0] end_pos;

  logic [SLOT_COUNT-1:0] hit_vec, free_vec, key_vec;
  logic          hit_c, free_c, keyend_c, layend_c, end_c;
  logic [SW-1:0] hit_idx_c, free_idx_c, keyend_idx_c, layend_idx_c, end_idx_c;
  logic          key_shared, layer_shared;

  ktas_result_t         res [RES_DEPTH];
  ktas_result_t         res_next [RES_DEPTH];
  logic [RES_CNT_W-1:0] res_cnt, res_cnt_next;
  logic [RES_CNT_W-1:0] ptr;

  logic          upd_en, upd_claim, upd_press, end_en;
  logic [SW-1:0] upd_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_mask   <= '0;
      layer_mask <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHARED_KEY:   key_mask   <= cfg_data[KEY_COUNT-1:0];
        REG_SHARED_LAYER: layer_mask <= cfg_data[LAYER_COUNT-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode     <= in_mode;
      position <= in_position;
      layer    <= in_layer;
      on       <= in_on;
    end
  end

  assign key_shared   = (32'(position) < KEY_COUNT) && key_mask[position[KW-1:0]];
  assign layer_shared = (32'(layer) < LAYER_COUNT) && layer_mask[layer[LW-1:0]];

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      hit_vec[i]  = slot_active[i] && (slot_position[i] == position);
      free_vec[i] = !slot_active[i];
      key_vec[i]  = slot_active[i] && (slot_position[i] != position);
    end
  end

  always_comb begin
    hit_c = 1'b0;  hit_idx_c = '0;
    free_c = 1'b0; free_idx_c = '0;
    keyend_c = 1'b0; keyend_idx_c = '0;
    layend_c = 1'b0; layend_idx_c = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_c = 1'b1; hit_idx_c = SW'(i);
      end
      if (free_vec[i]) begin
        free_c = 1'b1; free_idx_c = SW'(i);
      end
      if (key_vec[i]) begin
        keyend_c = 1'b1; keyend_idx_c = SW'(i);
      end
      if (slot_active[i]) begin
        layend_c = 1'b1; layend_idx_c = SW'(i);
      end
    end
  end

  always_comb begin
    case (mode)
      MODE_KEY: begin
        end_c     = keyend_c && !key_shared;
        end_idx_c = keyend_idx_c;
      end
      MODE_LAYER: begin
        end_c     = layend_c && on && !layer_shared;
        end_idx_c = layend_idx_c;
      end
      default: begin
        end_c     = 1'b0;
        end_idx_c = layend_idx_c;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      hit_found  <= hit_c;
      hit_idx    <= hit_idx_c;
      hit_first  <= slot_first[hit_idx_c];
      free_found <= free_c;
      free_idx   <= free_idx_c;
      end_found  <= end_c;
      end_idx    <= end_idx_c;
      end_pos    <= slot_position[end_idx_c];
      end_held   <= slot_held[end_idx_c];
    end
  end

  always_comb begin
    res_cnt_next = '0;
    for (int i = 0; i < RES_DEPTH; i++) begin
      res_next[i] = '0;
    end
    upd_en    = 1'b0;
    upd_claim = 1'b0;
    upd_press = 1'b0;
    upd_idx   = hit_idx;
    end_en    = 1'b0;
    case (mode)
      MODE_PRESS: begin
        if (hit_found || free_found) begin
          upd_en    = 1'b1;
          upd_press = 1'b1;
          upd_claim = !hit_found;
          upd_idx   = hit_found ? hit_idx : free_idx;
          if (!hit_found || hit_first) begin
            res_next[0]  = '{KIND_PRESS, ACT_TAP, position};
            res_next[1]  = '{KIND_RELEASE, ACT_TAP, position};
            res_next[2]  = '{KIND_PRESS, ACT_HOLD, position};
            res_cnt_next = 2'd3;
          end else begin
            res_next[0]  = '{KIND_PRESS, ACT_HOLD, position};
            res_cnt_next = 2'd1;
          end
        end else begin
          res_next[0]  = '{KIND_ERROR, ACT_TAP, position};
          res_cnt_next = 2'd1;
        end
      end
      MODE_RELEASE: begin
        if (hit_found) begin
          upd_en       = 1'b1;
          res_next[0]  = '{KIND_RELEASE, ACT_HOLD, position};
          res_cnt_next = 2'd1;
        end
      end
      default: begin
        if (end_found) begin
          end_en = 1'b1;
          if (end_held) begin
            res_next[0]  = '{KIND_RELEASE, ACT_HOLD, end_pos};
            res_next[1]  = '{KIND_PRESS, ACT_END, end_pos};
            res_next[2]  = '{KIND_RELEASE, ACT_END, end_pos};
            res_cnt_next = 2'd3;
          end else begin
            res_next[0]  = '{KIND_PRESS, ACT_END, end_pos};
            res_next[1]  = '{KIND_RELEASE, ACT_END, end_pos};
            res_cnt_next = 2'd2;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_active <= '0;
      slot_held   <= '0;
      slot_first  <= '0;
    end else if (cmd.apply) begin
      if (upd_en) begin
        slot_held[upd_idx] <= upd_press;
        if (upd_press) begin
          slot_first[upd_idx] <= 1'b0;
        end
        if (upd_claim) begin
          slot_active[upd_idx] <= 1'b1;
        end
      end
      if (end_en) begin
        slot_active[end_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply && upd_en && upd_claim) begin
      slot_position[upd_idx] <= position;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt <= '0;
      ptr     <= '0;
    end else if (cmd.apply) begin
      res_cnt <= res_cnt_next;
      ptr     <= '0;
    end else if (cmd.advance) begin
      ptr <= ptr + 2'd1;
    end
  end

  assign out_word           = res[ptr];
  assign out_last           = (ptr + 2'd1) == res_cnt;
  assign status.apply_empty = res_cnt_next == '0;
  assign status.last_word   = out_last;

endmodule

[rtl/key_tri_action_slot_engine.sv]
// ----------------------------------------------------------------------------
// key_tri_action_slot_engine
// Three-action key slot engine: claims, holds and ends key slots and issues
// the bound press and release actions for each key event.
// ----------------------------------------------------------------------------
//   channel  direction  handshake            payload
//   s_*      in         s_tvalid / s_tready  event word (mode, key, layer)
//   m_*      out        m_tvalid / m_tready  action word, m_tlast on last one
//   cfg_*    in         cfg_valid / cfg_ready shared key and layer masks
//
// One event at a time: accept, slot search, update, then the n action words
// (n is 0 to 3), one action word per cycle while m_tready is high.
// The slot search is one registered priority scan over all slots.
// A stalled m_tready holds the current action word; no event is taken until
// the last action word is delivered. rst clears all slots and both masks.
// cfg_ready stays high; write configuration only while idle.
// ----------------------------------------------------------------------------
module key_tri_action_slot_engine
  import ktas_pkg::*;
#(
  parameter int SLOT_COUNT  = 10,
  parameter int KEY_COUNT   = 64,
  parameter int LAYER_COUNT = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [S_TDATA_W-1:0]   s_tdata,   // key_position, layer_number, layer_on
  input  logic [MODE_W-1:0]      s_tuser,   // mode
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [M_TDATA_W-1:0]   m_tdata,   // action_index, action_position
  output logic [KIND_W-1:0]      m_tuser,   // action_kind
  output logic                   m_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  ktas_cmd_t    cmd;
  ktas_status_t status;
  ktas_result_t out_word;

  assign cfg_ready = 1'b1;

  ktas_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ktas_datapath #(
    .SLOT_COUNT  (SLOT_COUNT),
    .KEY_COUNT   (KEY_COUNT),
    .LAYER_COUNT (LAYER_COUNT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .in_mode     (s_tuser),
    .in_position (s_tdata[5:0]),
    .in_layer    (s_tdata[10:6]),
    .in_on       (s_tdata[11]),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_word    (out_word),
    .out_last    (m_tlast)
  );

  assign m_tdata = {out_word.position, out_word.index};
  assign m_tuser = out_word.kind;

endmodule

[rtl/ktas_checker.sv]
// ----------------------------------------------------------------------------
// ktas_checker
// Port-level checks of the key slot engine, bound to the top level.
// ----------------------------------------------------------------------------
module ktas_checker
  import ktas_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [M_TDATA_W-1:0]   m_tdata,
  input logic [KIND_W-1:0]      m_tuser,
  input logic                   m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("action word dropped while stalled");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> !m_tvalid)
    else $error("event taken while actions pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready && !m_tvalid)
    else $error("engine not busy after event");

  a_error_alone: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_ERROR |-> m_tlast && m_tdata[1:0] == ACT_TAP)
    else $error("no-slot error not a single tap word");

  a_kind_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser == KIND_PRESS || m_tuser == KIND_RELEASE ||
                 m_tuser == KIND_ERROR)
    else $error("undefined action kind");

endmodule

bind key_tri_action_slot_engine ktas_checker u_ktas_checker (.*);
